[rtl/core/lac_pkg.sv]
// Shared constants, codes and controller/datapath handshake types
// for the Life change-scan block. No dependencies.
`default_nettype none

package lac_pkg;

  // Default grid bounds handed to the top-level parameters
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Fixed field widths
  localparam int CFG_W      = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int POS_OUT_W  = 6;
  localparam int GEN_W      = 16;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;
  localparam logic [GEN_W-1:0] GEN_RESET     = 16'd1;
  localparam logic [GEN_W-1:0] GEN_MAX       = 16'hFFFF;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SCAN = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Row fetched from the current grid
  typedef enum logic [1:0] {
    RD_ABOVE,
    RD_CENTER,
    RD_BELOW
  } rd_sel_e;

  // Neighbor count phase
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_TOP,
    ACC_MID,
    ACC_FINAL
  } acc_e;

  typedef struct packed {
    logic    capture;
    logic    div_start;
    logic    load_write;
    logic    clear_write;
    logic    commit_write;
    logic    push;
    rd_sel_e rd_sel;
    acc_e    acc;
  } cmd_t;

  typedef struct packed {
    logic load_full;
    logic map_stale;
    logic div_done;
    logic scan_last;
    logic out_free;
    logic clear_last;
    logic commit_last;
  } stat_t;

endpackage

`default_nettype wire

[rtl/core/lac_in_if.sv]
// Input item channel: valid/ready plus function and cell value.
// Depends on lac_pkg.
`default_nettype none

interface lac_in_if
  import lac_pkg::*;
;
  logic valid;
  logic ready;
  logic func;
  logic cell_alive;

  modport source (output valid, output func, output cell_alive, input ready);
  modport sink   (input valid, input func, input cell_alive, output ready);
endinterface

`default_nettype wire

[rtl/core/lac_out_if.sv]
// Result channel: valid/ready plus change flag, position and generation.
// Depends on lac_pkg for field widths.
`default_nettype none

interface lac_out_if
  import lac_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 changed;
  logic [POS_OUT_W-1:0] row;
  logic [POS_OUT_W-1:0] col;
  logic [GEN_W-1:0]     generation;
  logic                 end_of_generation;

  modport source (output valid, output changed, output row, output col,
                  output generation, output end_of_generation, input ready);
  modport sink   (input valid, input changed, input row, input col,
                  input generation, input end_of_generation, output ready);
endinterface

`default_nettype wire

[rtl/core/lac_cfg.sv]
// APB register file for rows/cols in use, with clamping to the grid bounds.
// Depends on lac_pkg.
`default_nettype none

module lac_cfg
  import lac_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int RDW = $clog2(MAX_ROWS + 1),
  localparam int CDW = $clog2(MAX_COLS + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [RDW-1:0]        nr_o,
  output logic      [CDW-1:0]        nc_o
);

  logic [CFG_W-1:0] rows_q, rows_d;
  logic [CFG_W-1:0] cols_q, cols_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write decode
  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_ROWS: rows_d = pwdata[CFG_W-1:0];
        REG_COLS: cols_d = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_DIM_RESET;
      cols_q <= CFG_DIM_RESET;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ROWS: prdata = APB_DATA_W'(rows_q);
      REG_COLS: prdata = APB_DATA_W'(cols_q);
      default:  prdata = '0;
    endcase
  end

  // Zero counts as one, anything above the bound as the bound
  always_comb begin
    if (rows_q == '0)                    nr_o = RDW'(1);
    else if (32'(rows_q) > 32'(MAX_ROWS)) nr_o = RDW'(MAX_ROWS);
    else                                 nr_o = RDW'(rows_q);
    if (cols_q == '0)                    nc_o = CDW'(1);
    else if (32'(cols_q) > 32'(MAX_COLS)) nc_o = CDW'(MAX_COLS);
    else                                 nc_o = CDW'(cols_q);
  end

endmodule

`default_nettype wire

[rtl/core/lac_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Maps a linear load position onto row and column. Depends on lac_pkg.
`default_nettype none

module lac_div
  import lac_pkg::*;
#(
  parameter int N_W = 13,
  parameter int D_W = 7
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [N_W-1:0] dividend_i,
  input  wire logic [D_W-1:0] divisor_i,
  output logic                done_o,
  output logic      [N_W-1:0] quot_o,
  output logic      [D_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   q_q;
  logic [D_W-1:0]   r_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             ge;

  // One restoring step
  assign trial = {r_q, q_q[N_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(N_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Quotient and remainder shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
    end else if (busy_q) begin
      q_q <= {q_q[N_W-2:0], ge};
      r_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

[rtl/core/lac_ctrl.sv]
// Sequencer for clearing, loads, neighbor scans and the generation commit.
// Drives the datapath through cmd_t, watches stat_t. Depends on lac_pkg.
`default_nettype none

module lac_ctrl
  import lac_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_func_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_LD_DIV,
    ST_LD_WR,
    ST_RD_ABOVE,
    ST_RD_CENTER,
    ST_RD_BELOW,
    ST_ACC,
    ST_DELIVER,
    ST_CM_RD,
    ST_CM_WR
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    last_d         = last_q;
    in_ready_o     = (state_q == ST_IDLE);
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_CENTER;
    cmd_o.acc      = ACC_NONE;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_write = 1'b1;
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (in_func_i == FUNC_LOAD) ? ST_LOAD : ST_RD_ABOVE;
        end
      end
      ST_LOAD: begin
        if (!stat_i.load_full && stat_i.map_stale) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_LD_DIV;
        end else begin
          cmd_o.load_write = 1'b1;
          last_d  = 1'b0;
          state_d = ST_DELIVER;
        end
      end
      ST_LD_DIV: begin
        if (stat_i.div_done) state_d = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd_o.load_write = 1'b1;
        last_d  = 1'b0;
        state_d = ST_DELIVER;
      end
      ST_RD_ABOVE: begin
        cmd_o.rd_sel = RD_ABOVE;
        state_d = ST_RD_CENTER;
      end
      ST_RD_CENTER: begin
        cmd_o.rd_sel = RD_CENTER;
        cmd_o.acc    = ACC_TOP;
        state_d = ST_RD_BELOW;
      end
      ST_RD_BELOW: begin
        cmd_o.rd_sel = RD_BELOW;
        cmd_o.acc    = ACC_MID;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = ACC_FINAL;
        last_d  = stat_i.scan_last;
        state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d = last_q ? ST_CM_RD : ST_IDLE;
        end
      end
      ST_CM_RD: begin
        state_d = ST_CM_WR;
      end
      ST_CM_WR: begin
        cmd_o.commit_write = 1'b1;
        state_d = stat_i.commit_last ? ST_IDLE : ST_CM_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lac_dpath.sv]
// Grid memories, load mapping, neighbor counting, commit copy and output stage.
// Depends on lac_pkg and lac_div.
`default_nettype none

module lac_dpath
  import lac_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int RDW = $clog2(MAX_ROWS + 1),
  localparam int CDW = $clog2(MAX_COLS + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output stat_t                     stat_o,
  input  wire logic                 cell_alive_i,
  input  wire logic [RDW-1:0]       nr_i,
  input  wire logic [CDW-1:0]       nc_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic                      changed_o,
  output logic      [POS_OUT_W-1:0] row_o,
  output logic      [POS_OUT_W-1:0] col_o,
  output logic      [GEN_W-1:0]     generation_o,
  output logic                      eog_o
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int PW = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int TW = RDW + CDW;

  // Grid storage, one word per row
  logic [MAX_COLS-1:0] cur_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] nxt_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] cur_rdata_q;
  logic [MAX_COLS-1:0] nxt_rdata_q;

  logic                cur_we;
  logic [RW-1:0]       cur_waddr;
  logic [MAX_COLS-1:0] cur_wmask;
  logic [MAX_COLS-1:0] cur_wdata;
  logic [RW-1:0]       cur_raddr;
  logic                nxt_we;
  logic [RW-1:0]       nxt_waddr;
  logic [MAX_COLS-1:0] nxt_wmask;
  logic [MAX_COLS-1:0] nxt_wdata;

  // Load state
  logic [PW-1:0]  pos_q;
  logic [RW-1:0]  lrow_q;
  logic [CW-1:0]  lcol_q;
  logic [CDW-1:0] lnc_q;
  logic           alive_in_q;
  logic [TW-1:0]  total;
  logic           load_full;
  logic           div_done;
  logic [PW-1:0]  div_quot;
  logic [CDW-1:0] div_rem;

  // Scan state
  logic [RW-1:0]    srow_q;
  logic [CW-1:0]    scol_q;
  logic [GEN_W-1:0] gen_q;
  logic [3:0]       cnt_q;
  logic             self_q;
  logic [RW-1:0]    k_q;

  // Pending result and output stage
  logic                 pend_changed_q, pend_eog_q;
  logic [POS_OUT_W-1:0] pend_row_q, pend_col_q;
  logic [GEN_W-1:0]     pend_gen_q;
  logic                 out_valid_q;
  logic                 out_changed_q, out_eog_q;
  logic [POS_OUT_W-1:0] out_row_q, out_col_q;
  logic [GEN_W-1:0]     out_gen_q;

  // Scan position, restarted when it lies outside the grid in use
  logic          outside;
  logic [RW-1:0] fr;
  logic [CW-1:0] fc;
  logic          above_ok, below_ok, left_ok, right_ok;
  logic [RW:0]   fr_p1;
  logic [CW:0]   fc_p1;
  logic [RW-1:0] row_above, row_below;
  logic [CW-1:0] lidx, ridx;
  logic          lb, mb, rb;
  logic [1:0]    tri_sum, pair_sum;
  logic [3:0]    nsum;
  logic          changed;
  logic          scan_last;
  logic          new_val;

  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] lcol_bit;
  logic [MAX_COLS-1:0] fc_bit;

  assign outside   = (32'(srow_q) >= 32'(nr_i)) || (32'(scol_q) >= 32'(nc_i));
  assign fr        = outside ? '0 : srow_q;
  assign fc        = outside ? '0 : scol_q;
  assign fr_p1     = {1'b0, fr} + 1'b1;
  assign fc_p1     = {1'b0, fc} + 1'b1;
  assign above_ok  = (fr != '0);
  assign below_ok  = 32'(fr_p1) < 32'(nr_i);
  assign left_ok   = (fc != '0);
  assign right_ok  = 32'(fc_p1) < 32'(nc_i);
  assign row_above = above_ok ? fr - 1'b1 : fr;
  assign row_below = below_ok ? fr_p1[RW-1:0] : fr;
  assign lidx      = left_ok ? fc - 1'b1 : '0;
  assign ridx      = right_ok ? fc_p1[CW-1:0] : '0;
  assign scan_last = (32'(fr) == 32'(nr_i) - 32'd1) && (32'(fc) == 32'(nc_i) - 32'd1);

  // Neighbor bits from the fetched row word
  assign lb       = left_ok & cur_rdata_q[lidx];
  assign mb       = cur_rdata_q[fc];
  assign rb       = right_ok & cur_rdata_q[ridx];
  assign tri_sum  = {1'b0, lb} + {1'b0, mb} + {1'b0, rb};
  assign pair_sum = {1'b0, lb} + {1'b0, rb};
  assign nsum     = cnt_q + (below_ok ? {2'b00, tri_sum} : 4'd0);

  // B3/S23
  assign changed = self_q ? ((nsum < 4'd2) || (nsum > 4'd3)) : (nsum == 4'd3);
  assign new_val = self_q ^ changed;

  // Columns in use, and single-bit write masks
  for (genvar g = 0; g < MAX_COLS; g++) begin : g_col_mask
    assign col_mask[g] = (32'(g) < 32'(nc_i));
  end
  assign lcol_bit = MAX_COLS'(1) << lcol_q;
  assign fc_bit   = MAX_COLS'(1) << fc;

  assign total     = TW'(nr_i) * TW'(nc_i);
  assign load_full = 32'(pos_q) >= 32'(total);

  // Serial division of the load position by the column count
  lac_div #(
    .N_W (PW),
    .D_W (CDW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (pos_q),
    .divisor_i  (nc_i),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Write port selection
  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = k_q;
    cur_wmask = '1;
    cur_wdata = '0;
    if (cmd_i.clear_write) begin
      cur_we = 1'b1;
    end else if (cmd_i.load_write) begin
      cur_we    = !load_full;
      cur_waddr = lrow_q;
      cur_wmask = lcol_bit;
      cur_wdata = {MAX_COLS{alive_in_q}};
    end else if (cmd_i.commit_write) begin
      cur_we    = 1'b1;
      cur_wmask = col_mask;
      cur_wdata = nxt_rdata_q;
    end

    nxt_we    = 1'b0;
    nxt_waddr = k_q;
    nxt_wmask = '1;
    nxt_wdata = '0;
    if (cmd_i.clear_write) begin
      nxt_we = 1'b1;
    end else if (cmd_i.acc == ACC_FINAL) begin
      nxt_we    = 1'b1;
      nxt_waddr = fr;
      nxt_wmask = fc_bit;
      nxt_wdata = {MAX_COLS{new_val}};
    end
  end

  // Current-grid read address
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ABOVE:  cur_raddr = row_above;
      RD_CENTER: cur_raddr = fr;
      RD_BELOW:  cur_raddr = row_below;
      default:   cur_raddr = fr;
    endcase
  end

  // Memories with bit-masked write and registered read
  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        if (cur_wmask[j]) cur_mem[cur_waddr][j] <= cur_wdata[j];
      end
    end
    cur_rdata_q <= cur_mem[cur_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        if (nxt_wmask[j]) nxt_mem[nxt_waddr][j] <= nxt_wdata[j];
      end
    end
    nxt_rdata_q <= nxt_mem[k_q];
  end

  // Control registers: load mapping, scan position, generation, row sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      lrow_q      <= '0;
      lcol_q      <= '0;
      lnc_q       <= '0;
      srow_q      <= '0;
      scol_q      <= '0;
      gen_q       <= GEN_RESET;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (div_done) begin
        lrow_q <= div_quot[RW-1:0];
        lcol_q <= div_rem[CW-1:0];
        lnc_q  <= nc_i;
      end else if (cmd_i.load_write && !load_full) begin
        pos_q <= pos_q + 1'b1;
        if (32'(lcol_q) + 32'd1 >= 32'(nc_i)) begin
          lcol_q <= '0;
          lrow_q <= lrow_q + 1'b1;
        end else begin
          lcol_q <= lcol_q + 1'b1;
        end
      end

      if (cmd_i.acc == ACC_FINAL) begin
        if (scan_last) begin
          srow_q <= '0;
          scol_q <= '0;
          if (gen_q != GEN_MAX) gen_q <= gen_q + 1'b1;
        end else if (!right_ok) begin
          scol_q <= '0;
          srow_q <= fr_p1[RW-1:0];
        end else begin
          scol_q <= fc_p1[CW-1:0];
          srow_q <= fr;
        end
      end

      if (cmd_i.clear_write) begin
        k_q <= (32'(k_q) == 32'(MAX_ROWS - 1)) ? '0 : k_q + 1'b1;
      end else if (cmd_i.commit_write) begin
        k_q <= (32'(k_q) == 32'(nr_i) - 32'd1) ? '0 : k_q + 1'b1;
      end

      if (cmd_i.push)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Neighbor count and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) alive_in_q <= cell_alive_i;

    unique case (cmd_i.acc)
      ACC_NONE: ;
      ACC_TOP:  cnt_q <= above_ok ? {2'b00, tri_sum} : 4'd0;
      ACC_MID: begin
        cnt_q  <= cnt_q + {2'b00, pair_sum};
        self_q <= mb;
      end
      ACC_FINAL: begin
        pend_changed_q <= changed;
        pend_row_q     <= POS_OUT_W'(fr);
        pend_col_q     <= POS_OUT_W'(fc);
        pend_gen_q     <= gen_q;
        pend_eog_q     <= scan_last;
      end
    endcase

    if (cmd_i.load_write) begin
      pend_changed_q <= 1'b0;
      pend_row_q     <= '0;
      pend_col_q     <= '0;
      pend_gen_q     <= '0;
      pend_eog_q     <= 1'b0;
    end

    if (cmd_i.push) begin
      out_changed_q <= pend_changed_q;
      out_row_q     <= pend_row_q;
      out_col_q     <= pend_col_q;
      out_gen_q     <= pend_gen_q;
      out_eog_q     <= pend_eog_q;
    end
  end

  // Status back to the controller
  always_comb begin
    stat_o.load_full   = load_full;
    stat_o.map_stale   = (lnc_q != nc_i);
    stat_o.div_done    = div_done;
    stat_o.scan_last   = scan_last;
    stat_o.out_free    = !out_valid_q || out_ready_i;
    stat_o.clear_last  = (32'(k_q) == 32'(MAX_ROWS - 1));
    stat_o.commit_last = (32'(k_q) == 32'(nr_i) - 32'd1);
  end

  assign out_valid_o  = out_valid_q;
  assign changed_o    = out_changed_q;
  assign row_o        = out_row_q;
  assign col_o        = out_col_q;
  assign generation_o = out_gen_q;
  assign eog_o        = out_eog_q;

endmodule

`default_nettype wire

[rtl/core/life_automaton_change_scan.sv]
// Life (B3/S23) change scanner on a bounded grid. Each scan item takes three row
// fetches from the one-read-port grid memory before its result is registered.
// A load writes one cell; the first load after a change of column count first
// runs a serial division that maps the load position onto row and column.
// The last scan of a generation adds a commit copy of the next grid, row by row.
// After reset both grids are cleared over all MAX_ROWS rows before any item.
`default_nettype none

module life_automaton_change_scan
  import lac_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  lac_in_if.sink                     item_i,
  lac_out_if.source                  result_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int RDW = $clog2(MAX_ROWS + 1);
  localparam int CDW = $clog2(MAX_COLS + 1);

  logic [RDW-1:0]       nr;
  logic [CDW-1:0]       nc;
  cmd_t                 cmd;
  stat_t                stat;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_changed;
  logic [POS_OUT_W-1:0] out_row;
  logic [POS_OUT_W-1:0] out_col;
  logic [GEN_W-1:0]     out_gen;
  logic                 out_eog;

  // Configuration registers
  lac_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .nr_o    (nr),
    .nc_o    (nc)
  );

  // Sequencer
  lac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_func_i  (item_i.func),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Grid datapath and output stage
  lac_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cell_alive_i (item_i.cell_alive),
    .nr_i         (nr),
    .nc_i         (nc),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (out_valid),
    .changed_o    (out_changed),
    .row_o        (out_row),
    .col_o        (out_col),
    .generation_o (out_gen),
    .eog_o        (out_eog)
  );

  assign item_i.ready               = in_ready;
  assign result_o.valid             = out_valid;
  assign result_o.changed           = out_changed;
  assign result_o.row               = out_row;
  assign result_o.col               = out_col;
  assign result_o.generation        = out_gen;
  assign result_o.end_of_generation = out_eog;

endmodule

`default_nettype wire
